### rtl/core/modular_exponentiation_defines.svh
// assertion macros for the modular exponentiation block
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define MEXP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence in the next cycle
`define MEXP_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants and types of the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int unsigned WordBits = 63;
	localparam logic [62:0] ModulusReset = 63'd1000000007;

	// one-hot sequencer states
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RED  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_SQR  = 6'b001000,
		ST_NEXT = 6'b010000,
		ST_DONE = 6'b100000
	} mexp_state_t;

endpackage

### rtl/core/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base to the exponent modulo a configured modulus, right-to-left square
// and multiply over a bit-serial modular multiplier
// ----------------------------------------------------------------------------
// Pulse start while busy is low with base_value and exponent. The base is
// first reduced (one shift-subtract pass over the WORD_BITS base bits), then
// each exponent bit takes one decision state, one multiply pass when set and
// one square pass, each on the single shared multiplier; scanning stops once
// the remaining exponent bits are zero. The length and weight of the exponent
// set the time until the result is taken. The result is on power_result for
// one cycle with done high; the receiver cannot stall. busy drops in the
// result cycle, so the next word may start there. Write modulus only while
// busy is low; writes of zero are dropped. Exponent zero gives 1 for every
// modulus.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module modular_exponentiation import mexp_pkg::*; #(
	parameter int unsigned WORD_BITS = WordBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WORD_BITS-1:0] base_value,
	input  logic [WORD_BITS-1:0] exponent,
	input  logic                 cfg_we,
	input  logic [WORD_BITS-1:0] cfg_wdata,
	output logic                 done,
	output logic [WORD_BITS-1:0] power_result
);

	localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

	mexp_state_t          state_q;
	logic [WORD_BITS-1:0] modulus_q;
	logic [WORD_BITS-1:0] acc_q, sq_q, ex_q;
	logic [WORD_BITS-1:0] rin_q;     // base bits shifted into the reducer
	logic [CntBits-1:0]   cnt_q;
	logic                 go;
	logic [WORD_BITS-1:0] mb;
	logic                 mdone;
	logic [WORD_BITS-1:0] mp;
	logic [WORD_BITS:0]   rsh;

	// reducer step: shift in one base bit, subtract modulus once
	assign rsh = {sq_q, rin_q[WORD_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= WORD_BITS'(ModulusReset);
		end else if (cfg_we && cfg_wdata != '0) begin
			modulus_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done    <= 1'b0;
			go      <= 1'b0;
		end else begin
			done <= 1'b0;
			go   <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RED;
						cnt_q   <= CntBits'(WORD_BITS);
					end
				end
				ST_RED: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CntBits'(1)) state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (ex_q == '0) begin
						state_q <= ST_DONE;
					end else if (ex_q[0]) begin
						state_q <= ST_MUL;
						go      <= 1'b1;
					end else begin
						state_q <= ST_SQR;
						go      <= 1'b1;
					end
				end
				ST_MUL: begin
					if (mdone) begin
						state_q <= ST_SQR;
						go      <= 1'b1;
					end
				end
				ST_SQR: begin
					if (mdone) state_q <= ST_NEXT;
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					rin_q <= base_value;
					ex_q  <= exponent;
					sq_q  <= '0;
					acc_q <= WORD_BITS'(1);
				end
			end
			ST_RED: begin
				rin_q <= {rin_q[WORD_BITS-2:0], 1'b0};
				sq_q  <= (rsh >= {1'b0, modulus_q}) ? WORD_BITS'(rsh - {1'b0, modulus_q})
					: WORD_BITS'(rsh);
				// acc starts as 1 mod m so modulus one gives 0 for a nonzero exponent
				if (cnt_q == CntBits'(1) && modulus_q == WORD_BITS'(1)) acc_q <= '0;
			end
			ST_MUL: if (mdone) acc_q <= mp;
			ST_SQR: begin
				if (mdone) begin
					sq_q <= mp;
					ex_q <= {1'b0, ex_q[WORD_BITS-1:1]};
				end
			end
			default: ;
		endcase
	end

	// go is registered with the decision, so it is seen in the pass state itself
	always_comb begin
		mb = (state_q == ST_MUL) ? acc_q : sq_q;
	end

	mexp_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a      (sq_q),
		.b      (mb),
		.m      (modulus_q),
		.done   (mdone),
		.p      (mp)
	);

	logic zero_seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zero_seen_q <= 1'b0;
		else if (state_q == ST_IDLE && start) zero_seen_q <= (exponent == '0);
	end

	assign busy = (state_q != ST_IDLE);
	assign power_result = (zero_seen_q) ? WORD_BITS'(1) : acc_q;

	`MEXP_ASSERT(a_mod_nonzero, modulus_q != '0, "modulus became zero")
	`MEXP_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start not taken")
	`MEXP_ASSERT(a_done_idle, !(done && busy), "busy during result")

endmodule

### rtl/core/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial modular multiplier: add-and-double over the multiplier bits
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module mexp_mulmod import mexp_pkg::*; #(
	parameter int unsigned WORD_BITS = WordBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] p
);

	localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] b_q;
	logic [CntBits-1:0]   cnt_q;
	logic                 busy_q;
	logic [WORD_BITS:0]   dbl, dbl_r, add, add_r;
	logic [WORD_BITS-1:0] acc_d;

	// operands are already below m, so one subtract per step is enough
	always_comb begin
		dbl   = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
		add   = dbl_r + {1'b0, a};
		add_r = (add >= {1'b0, m}) ? add - {1'b0, m} : add;
		acc_d = b_q[WORD_BITS-1] ? add_r[WORD_BITS-1:0] : dbl_r[WORD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(WORD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= '0;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= acc_d;
			b_q   <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

	assign p = acc_q;

	`MEXP_ASSERT(a_go_idle, !(go && busy_q), "mulmod started while busy")
	`MEXP_ASSERT_NEXT(a_done_pulse, done, !done, "done longer than one cycle")
	`MEXP_ASSERT(a_done_idle, !(done && busy_q), "done while still busy")

endmodule
